/* hw/rtl/time_sorted_entry_table_core_macros.svh */
// Assertion macros for the time-sorted entry table checker.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef TIME_SORTED_ENTRY_TABLE_CORE_MACROS_SVH
`define TIME_SORTED_ENTRY_TABLE_CORE_MACROS_SVH

// Same-cycle implication.
`define TSET_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TSET_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/tset_pkg.sv */
// Shared types and constants for the time-sorted entry table.
// No dependencies; used by the cells, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package tset_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 64;
	localparam int unsigned MAX_W           = 7;
	localparam logic [MAX_W-1:0] MAX_ENTRIES_RST = 7'd64;

	typedef struct packed {
		logic [63:0] ident;
		logic [31:0] stime;
		logic [31:0] handle;
	} entry_t;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		RS_INSERTED  = 3'd0,
		RS_DUPLICATE = 3'd1,
		RS_FOUND     = 3'd2,
		RS_NOT_FOUND = 3'd3,
		RS_DELETED   = 3'd4,
		RS_CLEARED   = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE  = 2'd0,
		S_APPLY = 2'd1,
		S_EVICT = 2'd2
	} state_t;

	// What every cell does on the next edge.
	typedef enum logic [2:0] {
		CELL_HOLD     = 3'd0,
		CELL_INS      = 3'd1,  // open a slot at the insert point, shift up
		CELL_INS_DROP = 3'd2,  // insert and drop the head in one step
		CELL_DEL      = 3'd3,  // close the matched slot, shift down
		CELL_DROP     = 3'd4   // drop the head, shift down
	} cell_op_t;

	typedef struct packed {
		cell_op_t    op;
		logic        capture;    // register compare flags against the key
		logic [63:0] key_ident;
		logic [31:0] key_time;
		entry_t      new_entry;
	} cell_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/tset_intf.sv */
// Valid/ready channel interfaces for the command and response sides.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface tset_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [63:0] message_id;
	logic [31:0] send_time;
	logic [31:0] message_handle;

	modport source (output valid, command, message_id, send_time, message_handle,
		input ready);
	modport sink (input valid, command, message_id, send_time, message_handle,
		output ready);
endinterface

interface tset_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] found_time;
	logic [31:0] found_handle;
	logic [6:0]  evicted_count;
	logic [6:0]  occupancy;

	modport source (output valid, status, found_time, found_handle, evicted_count,
		occupancy, input ready);
	modport sink (input valid, status, found_time, found_handle, evicted_count,
		occupancy, output ready);
endinterface

`default_nettype wire

/* hw/rtl/time_sorted_entry_table_core.sv */
// Time-sorted entry table, top level: control sequencer and a row of cells.
// Uses tset_pkg, tset_cmd_if / tset_rsp_if and tset_cell.
//
// cmd_ch carries one command per transfer (insert, lookup, delete, clear);
// rsp_ch returns exactly one response per command, in order.
// cfg_wr_en / cfg_wr_data write max_entries; write only while no command is
// in flight. Values above TABLE_DEPTH act as TABLE_DEPTH.
// Timing: a command is taken in the cycle cmd_ch.ready is high; every cell
// compares its entry with the key at that edge. The sequencer then goes from
// idle to apply, where the cells shift and the response is registered once
// the output register is free; the next command can transfer back in idle.
// An insert that has to drop more than one entry (limit lowered) drops the
// rest from the head in the evict state, one entry per single-step shift of
// the cell row.
// The response waits in an output register; while it is not taken one more
// command can transfer, but its update stalls and cmd_ch.ready stays low.
// Reset empties the table (occupancy 0) and sets max_entries to 64; the
// stored entries themselves are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module time_sorted_entry_table_core
	import tset_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	tset_cmd_if.sink              cmd_ch,
	tset_rsp_if.source            rsp_ch,
	input  wire logic             cfg_wr_en,
	input  wire logic [MAX_W-1:0] cfg_wr_data
);

	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned LW = (CW > MAX_W) ? CW : MAX_W;

	state_t           state_q, state_d;
	cmd_t             cmd_q;
	entry_t           new_q;
	logic [CW-1:0]    count_q, count_d;
	logic [CW-1:0]    evict_q, evict_d;
	logic [MAX_W-1:0] max_entries_q;
	logic [CW-1:0]    limit;

	logic             out_valid_q;
	status_t          out_status_q;
	logic [31:0]      out_time_q;
	logic [31:0]      out_handle_q;
	logic [6:0]       out_evict_q;
	logic [6:0]       out_occ_q;

	cell_ctl_t        ctl;
	cell_op_t         op;
	logic             cmd_xfer;
	logic             slot_free;
	logic             hit;
	logic             finish;
	logic             to_evict;
	status_t          res_status;
	logic [31:0]      res_time;
	logic [31:0]      res_handle;
	logic [IW-1:0]    del_idx;
	entry_t           found_all;

	entry_t           cell_entry [TABLE_DEPTH];
	entry_t           cell_found [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] cell_ge;
	logic [TABLE_DEPTH-1:0] cell_match;

	assign cmd_ch.ready = (state_q == S_IDLE);
	assign cmd_xfer     = cmd_ch.valid && cmd_ch.ready;
	assign slot_free    = !out_valid_q || rsp_ch.ready;
	assign hit          = |cell_match;

	always_comb begin
		if (LW'(max_entries_q) > LW'(TABLE_DEPTH))
			limit = CW'(TABLE_DEPTH);
		else
			limit = CW'(max_entries_q);
	end

	// at most one slot matches: encode its index and merge its entry
	always_comb begin
		del_idx   = '0;
		found_all = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (cell_match[i])
				del_idx = del_idx | IW'(i);
			found_all = found_all | cell_found[i];
		end
	end

	assign ctl.op        = op;
	assign ctl.capture   = cmd_xfer;
	assign ctl.key_ident = cmd_ch.message_id;
	assign ctl.key_time  = cmd_ch.send_time;
	assign ctl.new_entry = new_q;

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		entry_t left_entry, right_entry;
		logic   left_ge, right_ge;

		if (g == 0) begin : g_head
			assign left_entry = new_q;
			assign left_ge    = 1'b0;
		end else begin : g_mid_l
			assign left_entry = cell_entry[g-1];
			assign left_ge    = cell_ge[g-1];
		end

		if (g == TABLE_DEPTH - 1) begin : g_tail
			assign right_entry = cell_entry[g];
			assign right_ge    = 1'b1;
		end else begin : g_mid_r
			assign right_entry = cell_entry[g+1];
			assign right_ge    = cell_ge[g+1];
		end

		tset_cell #(
			.DEPTH (TABLE_DEPTH),
			.IDX   (g)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.count       (count_q),
			.del_idx     (del_idx),
			.left_entry  (left_entry),
			.left_ge     (left_ge),
			.right_entry (right_entry),
			.right_ge    (right_ge),
			.entry       (cell_entry[g]),
			.ge          (cell_ge[g]),
			.match       (cell_match[g]),
			.found       (cell_found[g])
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_xfer)
					state_d = S_APPLY;
			end
			S_APPLY: begin
				if (to_evict)
					state_d = S_EVICT;
				else if (finish)
					state_d = S_IDLE;
			end
			S_EVICT: begin
				if (finish)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs: cell operation, counters, response
	always_comb begin
		op         = CELL_HOLD;
		count_d    = count_q;
		evict_d    = evict_q;
		finish     = 1'b0;
		to_evict   = 1'b0;
		res_status = RS_INSERTED;
		res_time   = '0;
		res_handle = '0;
		case (state_q)
			S_IDLE: ;
			S_APPLY: begin
				if (slot_free) begin
					evict_d = '0;
					case (cmd_q)
						CMD_INSERT: begin
							if (hit) begin
								res_status = RS_DUPLICATE;
								finish     = 1'b1;
							end else if (count_q < limit) begin
								op      = CELL_INS;
								count_d = count_q + 1'b1;
								finish  = 1'b1;
							end else begin
								// table at or above limit: the head goes in the same step
								op      = CELL_INS_DROP;
								evict_d = CW'(1);
								if (count_q > limit)
									to_evict = 1'b1;
								else
									finish = 1'b1;
							end
						end
						CMD_LOOKUP: begin
							finish = 1'b1;
							if (hit) begin
								res_status = RS_FOUND;
								res_time   = found_all.stime;
								res_handle = found_all.handle;
							end else begin
								res_status = RS_NOT_FOUND;
							end
						end
						CMD_DELETE: begin
							finish = 1'b1;
							if (hit) begin
								op         = CELL_DEL;
								count_d    = count_q - 1'b1;
								res_status = RS_DELETED;
							end else begin
								res_status = RS_NOT_FOUND;
							end
						end
						CMD_CLEAR: begin
							finish     = 1'b1;
							count_d    = '0;
							res_status = RS_CLEARED;
						end
						default: ;
					endcase
				end
			end
			S_EVICT: begin
				if (count_q > limit) begin
					op      = CELL_DROP;
					count_d = count_q - 1'b1;
					evict_d = evict_q + 1'b1;
				end else if (slot_free) begin
					finish = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			evict_q       <= '0;
			max_entries_q <= MAX_ENTRIES_RST;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			evict_q <= evict_d;
			if (cfg_wr_en)
				max_entries_q <= cfg_wr_data;
			if (finish)
				out_valid_q <= 1'b1;
			else if (rsp_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			cmd_q        <= cmd_t'(cmd_ch.command);
			new_q.ident  <= cmd_ch.message_id;
			new_q.stime  <= cmd_ch.send_time;
			new_q.handle <= cmd_ch.message_handle;
		end
		if (finish) begin
			out_status_q <= res_status;
			out_time_q   <= res_time;
			out_handle_q <= res_handle;
			out_evict_q  <= 7'(evict_d);
			out_occ_q    <= 7'(count_d);
		end
	end

	assign rsp_ch.valid         = out_valid_q;
	assign rsp_ch.status        = out_status_q;
	assign rsp_ch.found_time    = out_time_q;
	assign rsp_ch.found_handle  = out_handle_q;
	assign rsp_ch.evicted_count = out_evict_q;
	assign rsp_ch.occupancy     = out_occ_q;

endmodule

`default_nettype wire

/* hw/rtl/tset_cell.sv */
// One slot of the sorted table: holds an entry, compares it against the key
// and takes data from itself, a neighbor or the new entry. Uses tset_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tset_cell
	import tset_pkg::*;
#(
	parameter int unsigned DEPTH = TABLE_DEPTH_DEF,
	parameter int unsigned IDX   = 0,
	localparam int unsigned CW   = $clog2(DEPTH + 1),
	localparam int unsigned IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cell_ctl_t     ctl,
	input  wire logic [CW-1:0] count,
	input  wire logic [IW-1:0] del_idx,
	input  wire entry_t        left_entry,
	input  wire logic          left_ge,
	input  wire entry_t        right_entry,
	input  wire logic          right_ge,
	output entry_t             entry,
	output logic               ge,
	output logic               match,
	output entry_t             found
);

	entry_t entry_q;
	entry_t entry_d;
	logic   match_q;
	logic   ge_q;
	logic   occ;
	logic   at_k;

	assign occ  = CW'(IDX) < count;
	assign at_k = IW'(IDX) >= del_idx;

	// ge: this slot sits at or after the insert point (empty slots count too)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			ge_q    <= 1'b0;
		end else if (ctl.capture) begin
			match_q <= occ && (entry_q.ident == ctl.key_ident);
			ge_q    <= !occ || (entry_q.stime > ctl.key_time);
		end
	end

	always_comb begin
		entry_d = entry_q;
		case (ctl.op)
			CELL_HOLD: entry_d = entry_q;
			CELL_INS: begin
				if (ge_q && !left_ge)
					entry_d = ctl.new_entry;
				else if (ge_q)
					entry_d = left_entry;
			end
			CELL_INS_DROP: begin
				if (!right_ge)
					entry_d = right_entry;
				else if (!ge_q)
					entry_d = ctl.new_entry;
			end
			CELL_DEL: begin
				if (at_k)
					entry_d = right_entry;
			end
			CELL_DROP: entry_d = right_entry;
			default: entry_d = entry_q;
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign entry = entry_q;
	assign ge    = ge_q;
	assign match = match_q;
	assign found = match_q ? entry_q : '0;

endmodule

`default_nettype wire

/* hw/rtl/tset_checker.sv */
// Port-level checks for the time-sorted entry table, bound to the top level.
// Uses tset_pkg and the macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "time_sorted_entry_table_core_macros.svh"

module tset_checker
	import tset_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cmd_valid,
	input wire logic        cmd_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [2:0]  status,
	input wire logic [31:0] found_time,
	input wire logic [31:0] found_handle,
	input wire logic [6:0]  evicted_count,
	input wire logic [6:0]  occupancy
);

	`TSET_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

	`TSET_ASSERT_NEXT(a_one_in_flight, cmd_valid && cmd_ready, !cmd_ready, "command taken while busy")

	`TSET_ASSERT_NOW(a_clear_empty, rsp_valid && (status == RS_CLEARED), occupancy == 7'd0, "clear left entries")

	`TSET_ASSERT_NOW(a_found_only, rsp_valid && (status != RS_FOUND), (found_time == 32'd0) && (found_handle == 32'd0), "found data without a hit")

	`TSET_ASSERT_NOW(a_evict_insert, rsp_valid && (status != RS_INSERTED), evicted_count == 7'd0, "eviction outside insert")

endmodule

bind time_sorted_entry_table_core tset_checker u_tset_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd_ch.valid),
	.cmd_ready     (cmd_ch.ready),
	.rsp_valid     (rsp_ch.valid),
	.rsp_ready     (rsp_ch.ready),
	.status        (rsp_ch.status),
	.found_time    (rsp_ch.found_time),
	.found_handle  (rsp_ch.found_handle),
	.evicted_count (rsp_ch.evicted_count),
	.occupancy     (rsp_ch.occupancy)
);

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for time_sorted_entry_table_core: directed and random commands.
// A scoreboard class predicts each response; depends on tset_pkg and tset_intf.sv.
`timescale 1ns / 1ps

module testbench;
	import tset_pkg::*;

	localparam int POOL_SIZE   = 96;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 10;

	typedef struct packed {
		status_t     status;
		logic [31:0] found_time;
		logic [31:0] found_handle;
		logic [6:0]  evicted_count;
		logic [6:0]  occupancy;
	} response_t;

	class table_scoreboard;
		entry_t      rows[$];
		int unsigned limit;
		response_t   due[$];
		int          errors;

		function new();
			limit  = MAX_ENTRIES_RST;
			errors = 0;
		endfunction

		function void set_limit(logic [MAX_W-1:0] v);
			limit = v;
		endfunction

		function int pending();
			return due.size();
		endfunction

		function int locate(logic [63:0] id);
			int i;
			for (i = 0; i < rows.size(); i++)
				if (rows[i].ident == id) return i;
			return -1;
		endfunction

		// Apply one accepted command to the shadow table and queue its response.
		function void note_command(cmd_t cmd, logic [63:0] id, logic [31:0] t,
				logic [31:0] h);
			response_t   r;
			entry_t      e;
			int          k;
			int          pos;
			int          i;
			int unsigned cap;
			r = '0;
			k = locate(id);
			case (cmd)
				CMD_INSERT: begin
					if (k >= 0) begin
						r.status = RS_DUPLICATE;
					end else begin
						pos = rows.size();
						for (i = 0; i < rows.size(); i++)
							if (rows[i].stime > t) begin
								pos = i;
								break;
							end
						e = '{ident: id, stime: t, handle: h};
						rows.insert(pos, e);
						cap = (limit < TABLE_DEPTH_DEF) ? limit : TABLE_DEPTH_DEF;
						// earliest entries go first, the new one included
						while (rows.size() > cap) begin
							rows.delete(0);
							r.evicted_count = r.evicted_count + 7'd1;
						end
						r.status = RS_INSERTED;
					end
				end
				CMD_LOOKUP: begin
					if (k >= 0) begin
						r.status       = RS_FOUND;
						r.found_time   = rows[k].stime;
						r.found_handle = rows[k].handle;
					end else begin
						r.status = RS_NOT_FOUND;
					end
				end
				CMD_DELETE: begin
					if (k >= 0) begin
						rows.delete(k);
						r.status = RS_DELETED;
					end else begin
						r.status = RS_NOT_FOUND;
					end
				end
				default: begin
					rows.delete();
					r.status = RS_CLEARED;
				end
			endcase
			r.occupancy = 7'(rows.size());
			due.insert(due.size(), r);
		endfunction

		task report_mismatch(string msg);
			$display("%0t mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_response(response_t got);
			response_t want;
			if (due.size() == 0) begin
				report_mismatch($sformatf("response with none pending, status %0d", got.status));
				return;
			end
			want = due.pop_front();
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.found_time !== want.found_time)
				report_mismatch($sformatf("found_time %h, want %h",
					got.found_time, want.found_time));
			if (got.found_handle !== want.found_handle)
				report_mismatch($sformatf("found_handle %h, want %h",
					got.found_handle, want.found_handle));
			if (got.evicted_count !== want.evicted_count)
				report_mismatch($sformatf("evicted_count %0d, want %0d",
					got.evicted_count, want.evicted_count));
			if (got.occupancy !== want.occupancy)
				report_mismatch($sformatf("occupancy %0d, want %0d",
					got.occupancy, want.occupancy));
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [MAX_W-1:0] cfg_wr_data;

	tset_cmd_if cmd_ch ();
	tset_rsp_if rsp_ch ();

	time_sorted_entry_table_core #(
		.TABLE_DEPTH(TABLE_DEPTH_DEF)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_ch     (cmd_ch),
		.rsp_ch     (rsp_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	table_scoreboard sb;
	int              send_idle_pct;
	int              stall_pct;
	int unsigned     hold_seq;
	logic [63:0]     id_pool [POOL_SIZE];

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#3_000_000;
		$display("FAIL time_sorted_entry_table_core");
		$finish;
	end

	// response side: random stalls, plus one long hold-off per request
	initial begin
		int unsigned holds_done;
		holds_done = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seq != holds_done) begin
				holds_done = hold_seq;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		response_t got;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got.status        = status_t'(rsp_ch.status);
			got.found_time    = rsp_ch.found_time;
			got.found_handle  = rsp_ch.found_handle;
			got.evicted_count = rsp_ch.evicted_count;
			got.occupancy     = rsp_ch.occupancy;
			sb.check_response(got);
		end
	end

	// Offer one command and return at the edge where it transfers.
	task automatic send_command(cmd_t cmd, logic [63:0] id, logic [31:0] t, logic [31:0] h);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		cmd_ch.valid          <= 1'b1;
		cmd_ch.command        <= cmd;
		cmd_ch.message_id     <= id;
		cmd_ch.send_time      <= t;
		cmd_ch.message_handle <= h;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		sb.note_command(cmd, id, t, h);
	endtask

	task automatic random_command(int ins_pct);
		int unsigned r;
		cmd_t        cmd;
		logic [63:0] id;
		logic [31:0] t;
		r = $urandom_range(99);
		if (r < ins_pct) cmd = CMD_INSERT;
		else if (r < ins_pct + (98 - ins_pct) / 2) cmd = CMD_LOOKUP;
		else if (r < 98) cmd = CMD_DELETE;
		else cmd = CMD_CLEAR;
		if ($urandom_range(99) < 90) id = id_pool[$urandom_range(POOL_SIZE - 1)];
		else id = {$urandom, $urandom};
		// small times give many ties and early arrivals
		r = $urandom_range(99);
		if (r < 50) t = $urandom_range(15);
		else if (r < 80) t = $urandom;
		else if (r < 90) t = '0;
		else t = '1;
		send_command(cmd, id, t, $urandom);
	endtask

	task automatic wait_drain();
		cmd_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_limit(logic [MAX_W-1:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_limit(v);
	endtask

	task automatic run_phase(int n, int ins_pct, int idle_pct, int rx_stall_pct, bit pressure);
		send_idle_pct = idle_pct;
		stall_pct     = rx_stall_pct;
		if (pressure)
			hold_seq++;
		repeat (n) random_command(ins_pct);
		wait_drain();
	endtask

	initial begin
		sb            = new();
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_seq      = 0;
		id_pool[0]    = '0;
		id_pool[1]    = '1;
		for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = {$urandom, $urandom};

		arst_n                <= 1'b0;
		cfg_wr_en             <= 1'b0;
		cfg_wr_data           <= '0;
		cmd_ch.valid          <= 1'b0;
		cmd_ch.command        <= CMD_INSERT;
		cmd_ch.message_id     <= '0;
		cmd_ch.send_time      <= '0;
		cmd_ch.message_handle <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed: empty table, extremes, ties, duplicate, missing ids
		write_limit(7'd64);
		send_command(CMD_LOOKUP, 64'h0, '0, '0);
		send_command(CMD_DELETE, 64'h0, '0, '0);
		send_command(CMD_INSERT, 64'h0, 32'h0, 32'h0);
		send_command(CMD_INSERT, '1, '1, '1);
		send_command(CMD_INSERT, 64'h5555_5555_5555_5555, 32'h0, 32'hA5A5_A5A5);
		send_command(CMD_INSERT, 64'h0, 32'd7, 32'd7);
		send_command(CMD_LOOKUP, 64'h0, '0, '0);
		send_command(CMD_LOOKUP, '1, '0, '0);
		send_command(CMD_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, '0, '0);
		send_command(CMD_DELETE, '1, '0, '0);
		send_command(CMD_DELETE, 64'hAAAA_AAAA_AAAA_AAAA, '0, '0);
		send_command(CMD_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'd100, 32'd1);
		send_command(CMD_INSERT, 64'h1234_5678_9ABC_DEF0, 32'd50, 32'h5A5A_5A5A);
		send_command(CMD_INSERT, 64'h0F0F_0F0F_0F0F_0F0F, '1, 32'h8000_0001);
		wait_drain();
		// lowered limit: next insert drops several; then an earliest entry drops itself
		write_limit(7'd2);
		send_command(CMD_INSERT, 64'hC3C3_C3C3_C3C3_C3C3, 32'd200, 32'd2);
		send_command(CMD_INSERT, 64'h3C3C_3C3C_3C3C_3C3C, 32'd1, 32'd3);
		send_command(CMD_LOOKUP, 64'h3C3C_3C3C_3C3C_3C3C, '0, '0);
		wait_drain();
		// zero limit: insert succeeds and empties the table
		write_limit(7'd0);
		send_command(CMD_INSERT, 64'h0123_4567_89AB_CDEF, 32'd9, 32'd9);
		send_command(CMD_LOOKUP, 64'h0123_4567_89AB_CDEF, '0, '0);
		wait_drain();
		// limit above depth saturates
		write_limit(7'd127);
		send_command(CMD_INSERT, 64'hFEDC_BA98_7654_3210, 32'd5, 32'd6);
		send_command(CMD_CLEAR, '0, '0, '0);
		send_command(CMD_CLEAR, '0, '0, '0);
		wait_drain();

		write_limit(7'd64);
		run_phase(150, 75, 0, 0, 1'b0);
		write_limit(7'd127);
		run_phase(90, 55, 48, 0, 1'b0);
		write_limit(7'd5);
		run_phase(90, 50, 0, 48, 1'b0);
		write_limit(7'd0);
		run_phase(30, 60, 34, 34, 1'b0);
		write_limit(7'd1);
		run_phase(40, 60, 34, 34, 1'b0);
		write_limit(7'd64);
		run_phase(120, 70, 0, 0, 1'b1);
		write_limit(7'($urandom_range(63, 2)));
		run_phase(110, 55, 34, 34, 1'b0);

		if (sb.errors == 0) begin
			$display("PASS time_sorted_entry_table_core");
		end else begin
			$display("FAIL time_sorted_entry_table_core");
		end
		$finish;
	end

endmodule
